// ----- rtl/cpr_pkg.sv -----
// Package for the clock page replacement block.
// Holds field widths, codes, register reset values and the memory write struct.
// Used by every file in rtl; it depends on nothing.
package cpr_pkg;

  localparam int INDEX_W          = 6;
  localparam int VICTIM_W         = 6;
  localparam int FC_W             = 7;
  localparam int MAX_FRAMES_DEF   = 64;

  localparam logic FUNC_REF       = 1'b0;
  localparam logic FUNC_VICTIM    = 1'b1;

  localparam logic MODE_FIFO      = 1'b0;
  localparam logic MODE_CLOCK     = 1'b1;

  localparam logic REG_POLICY     = 1'b0;
  localparam logic REG_FRAMES     = 1'b1;

  localparam logic            POLICY_RESET = MODE_CLOCK;
  localparam logic [FC_W-1:0] FRAMES_RESET = 7'd64;

  typedef struct packed {
    logic en;
    logic data;
  } mem_wr_t;

endpackage

// ----- rtl/cpr_ref_mem.sv -----
// Referenced-bit store: one bit per frame, one write and one read port.
// Read data is registered. Uses cpr_pkg.
module cpr_ref_mem #(
  parameter int DEPTH = cpr_pkg::MAX_FRAMES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  cpr_pkg::mem_wr_t wr,
  input  logic [AW-1:0]    wr_addr,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic             rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/cpr_hand_fsm.sv -----
// Hand sequencer: clearing pass, reference writes, victim search and result register.
// Drives the ports of cpr_ref_mem. Uses cpr_pkg.
module cpr_hand_fsm #(
  parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
  parameter int AW         = $clog2(MAX_FRAMES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         policy_mode,
  input  logic [cpr_pkg::FC_W-1:0]     frame_count,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [cpr_pkg::INDEX_W-1:0]  in_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cpr_pkg::VICTIM_W-1:0] out_victim,
  output cpr_pkg::mem_wr_t             mem_wr,
  output logic [AW-1:0]                mem_wr_addr,
  output logic                         mem_rd_en,
  output logic [AW-1:0]                mem_rd_addr,
  input  logic                         mem_rd_data
);

  localparam int CW = (AW + 1 > cpr_pkg::FC_W) ? AW + 1 : cpr_pkg::FC_W;

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    CHECK,
    OUTPUT
  } state_t;

  state_t        state;
  logic [AW-1:0] hand;
  logic [AW-1:0] pos;
  logic [AW-1:0] victim;
  logic [AW-1:0] clr_addr;
  logic          fwd_hit;

  logic [CW-1:0] fc_ext;
  logic [CW-1:0] n_frames;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] victim_ext;
  logic [AW-1:0] start_pos;
  logic [AW-1:0] start_adv;
  logic [AW-1:0] pos_adv;
  logic          accept;
  logic          ref_ok;
  logic          bit_set;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p, input logic [CW-1:0] cnt);
    logic [CW-1:0] q;
    q = CW'(p) + CW'(1);
    return (q >= cnt) ? '0 : q[AW-1:0];
  endfunction

  always_comb begin
    fc_ext = CW'(frame_count);
    if (fc_ext == '0) begin
      n_frames = CW'(1);
    end else if (fc_ext > CW'(MAX_FRAMES)) begin
      n_frames = CW'(MAX_FRAMES);
    end else begin
      n_frames = fc_ext;
    end
  end

  assign idx_ext    = CW'(in_index);
  assign ref_ok     = idx_ext < CW'(MAX_FRAMES);
  assign start_pos  = (CW'(hand) >= n_frames) ? '0 : hand;
  assign start_adv  = advance(start_pos, n_frames);
  assign pos_adv    = advance(pos, n_frames);
  assign in_ready   = (state == IDLE);
  assign accept     = in_valid && in_ready;
  assign bit_set    = mem_rd_data && !fwd_hit;
  assign victim_ext = CW'(victim);

  always_comb begin
    mem_wr      = '0;
    mem_wr_addr = clr_addr;
    mem_rd_en   = 1'b0;
    mem_rd_addr = start_pos;
    case (state)
      CLEAR: begin
        mem_wr.en = 1'b1;
      end
      IDLE: begin
        if (accept && in_func == cpr_pkg::FUNC_REF && ref_ok) begin
          mem_wr.en   = 1'b1;
          mem_wr.data = 1'b1;
          mem_wr_addr = idx_ext[AW-1:0];
        end
        if (accept && in_func == cpr_pkg::FUNC_VICTIM && policy_mode == cpr_pkg::MODE_CLOCK) begin
          mem_rd_en = 1'b1;
        end
      end
      CHECK: begin
        if (bit_set) begin
          mem_wr.en   = 1'b1;
          mem_wr_addr = pos;
          mem_rd_en   = 1'b1;
          mem_rd_addr = pos_adv;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      clr_addr  <= '0;
      hand      <= '0;
      out_valid <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      if (state == OUTPUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_FRAMES - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept && in_func == cpr_pkg::FUNC_VICTIM) begin
            if (policy_mode == cpr_pkg::MODE_FIFO) begin
              victim <= start_pos;
              hand   <= start_adv;
              state  <= OUTPUT;
            end else begin
              pos     <= start_pos;
              fwd_hit <= 1'b0;
              state   <= CHECK;
            end
          end
        end
        CHECK: begin
          if (bit_set) begin
            pos     <= pos_adv;
            fwd_hit <= (pos_adv == pos);
          end else begin
            victim <= pos;
            hand   <= pos_adv;
            state  <= OUTPUT;
          end
        end
        OUTPUT: begin
          if (!out_valid || out_ready) begin
            out_victim <= victim_ext[cpr_pkg::VICTIM_W-1:0];
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hand_in_range: assert property (@(posedge clk) disable iff (rst)
    CW'(hand) < CW'(MAX_FRAMES))
    else $error("hand beyond frame store");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == CLEAR |-> !in_ready)
    else $error("item accepted during clearing pass");

  a_result_from_output: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(state) == OUTPUT)
    else $error("result loaded outside output state");

  a_check_write_read: assert property (@(posedge clk) disable iff (rst)
    state == CHECK && mem_wr.en |-> mem_rd_en && mem_wr_addr == pos && !mem_wr.data)
    else $error("bad clear during victim search");
`endif

endmodule

// ----- rtl/clock_page_replacement.sv -----
// Top level of the clock page replacement victim selector.
// Holds the APB registers and connects cpr_hand_fsm to cpr_ref_mem; uses cpr_pkg.
//
// After reset the block clears the referenced bits of all MAX_FRAMES frames and
// accepts no item until that pass is over; register writes are taken at any time.
// A victim request in FIFO mode takes the frame at the hand without a search. In
// clock mode the hand examines one frame per cycle through the single-bit memory
// and clears each set bit that it passes before it finds a victim (at most the
// number of frames in use). A finished result waits in an output register while
// the next item is accepted.
module clock_page_replacement #(
  parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] frame_index, [7:6] zero
  input  logic        s_axis_tuser,   // [0] func
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [5:0] victim_frame, [7:6] zero
);

  localparam int AW = $clog2(MAX_FRAMES);

  logic                         policy_mode;
  logic [cpr_pkg::FC_W-1:0]     frame_count;
  logic                         cfg_wr;
  logic [cpr_pkg::VICTIM_W-1:0] victim;

  cpr_pkg::mem_wr_t mem_wr;
  logic [AW-1:0]    mem_wr_addr;
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic             mem_rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= cpr_pkg::POLICY_RESET;
      frame_count <= cpr_pkg::FRAMES_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        cpr_pkg::REG_POLICY: policy_mode <= pwdata[0];
        cpr_pkg::REG_FRAMES: frame_count <= pwdata[cpr_pkg::FC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cpr_pkg::REG_POLICY: prdata = {31'd0, policy_mode};
      cpr_pkg::REG_FRAMES: prdata = {{(32 - cpr_pkg::FC_W){1'b0}}, frame_count};
      default:             prdata = '0;
    endcase
  end

  assign m_axis_tdata = {2'b00, victim};

  cpr_hand_fsm #(
    .MAX_FRAMES (MAX_FRAMES),
    .AW         (AW)
  ) u_fsm (
    .clk         (clk),
    .rst         (rst),
    .policy_mode (policy_mode),
    .frame_count (frame_count),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_func     (s_axis_tuser),
    .in_index    (s_axis_tdata[cpr_pkg::INDEX_W-1:0]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_victim  (victim),
    .mem_wr      (mem_wr),
    .mem_wr_addr (mem_wr_addr),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  cpr_ref_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .wr_addr (mem_wr_addr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ----- tb/tb_clock_page_replacement.sv -----
// Self-checking testbench for the clock page replacement victim selector.
// Tracks referenced bits and the hand in its own model of the block and checks every victim.
// Depends on cpr_pkg and clock_page_replacement from rtl.
module tb_clock_page_replacement;
  import cpr_pkg::*;

  localparam int FRAMES_MAX = MAX_FRAMES_DEF;
  localparam int SETTLE_CYCLES = FRAMES_MAX + 16;
  localparam int DRAIN_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [5:0] frame_index, [7:6] zero
  logic        s_axis_tuser = 1'b0; // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [5:0] victim_frame, [7:6] zero

  // Shadow of the block's registers and state.
  logic                  policy_shadow;
  logic [FC_W-1:0]       frames_shadow;
  int                    hand_shadow;
  logic [FRAMES_MAX-1:0] ref_bits_shadow;
  logic [VICTIM_W-1:0]   pending_victims[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int errors = 0;
  int refs_sent = 0;
  int victims_sent = 0;
  int victims_checked = 0;
  int settings_written = 0;

  clock_page_replacement i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  function automatic int frames_used();
    int n;
    n = int'(frames_shadow);
    if (n < 1) n = 1;
    if (n > FRAMES_MAX) n = FRAMES_MAX;
    return n;
  endfunction

  task automatic track_access(input logic fn, input logic [INDEX_W-1:0] idx);
    int n;
    int pos;
    int victim;
    if (fn == FUNC_REF) begin
      ref_bits_shadow[idx] = 1'b1;
      refs_sent++;
      return;
    end
    victims_sent++;
    n = frames_used();
    pos = (hand_shadow >= n) ? 0 : hand_shadow;
    victim = pos;
    if (policy_shadow == MODE_FIFO) begin
      pos = (pos + 1 >= n) ? 0 : pos + 1;
    end else begin
      for (int t = 0; t <= n; t++) begin
        victim = pos;
        pos = (pos + 1 >= n) ? 0 : pos + 1;
        if (ref_bits_shadow[victim]) begin
          ref_bits_shadow[victim] = 1'b0;
        end else begin
          break;
        end
      end
    end
    hand_shadow = pos;
    pending_victims.push_back(victim[VICTIM_W-1:0]);
  endtask

  // Result checker.
  always @(posedge clk) begin
    logic [VICTIM_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_victims.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: unexpected result transfer, victim_frame %0d", m_axis_tdata[5:0]);
      end else begin
        want = pending_victims.pop_front();
        victims_checked++;
        if (m_axis_tdata !== {2'b00, want}) begin
          errors++;
          if (errors <= 10)
            $display("tb: victim_frame mismatch, expected %0d, got tdata 0x%02h",
                     want, m_axis_tdata);
        end
      end
    end
  end

  // Result ready, with random stalls and long hold-offs on request.
  always @(posedge clk) begin
    int hold_left;
    int hold_seen;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic fn, input logic [INDEX_W-1:0] idx);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {2'b00, idx};
    do @(posedge clk); while (!s_axis_tready);
    track_access(fn, idx);
  endtask

  // Stops the stream and waits until every victim has arrived and the block is idle.
  task automatic settle();
    int c;
    s_axis_tvalid <= 1'b0;
    c = 0;
    while (pending_victims.size() != 0 && c < DRAIN_LIMIT) begin
      @(posedge clk);
      c++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [31:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (index == REG_POLICY) policy_shadow = value[0];
    else frames_shadow = value[FC_W-1:0];
    settings_written++;
  endtask

  task automatic test_clock_basics();
    send_item(FUNC_VICTIM, 6'd63);
    send_item(FUNC_VICTIM, 6'd0);
    send_item(FUNC_REF, 6'd3);
    send_item(FUNC_REF, 6'd63);
    send_item(FUNC_REF, 6'd2);
    send_item(FUNC_VICTIM, 6'd21);
    send_item(FUNC_VICTIM, 6'd42);
  endtask

  task automatic test_full_sweep();
    write_reg(REG_FRAMES, 32'd4);
    for (int f = 0; f < 4; f++) send_item(FUNC_REF, f[INDEX_W-1:0]);
    send_item(FUNC_VICTIM, 6'd0);
    send_item(FUNC_VICTIM, 6'd0);
  endtask

  task automatic test_fifo_rotation();
    write_reg(REG_POLICY, {31'd0, MODE_FIFO});
    send_item(FUNC_REF, 6'd1);
    send_item(FUNC_VICTIM, 6'd1);
    send_item(FUNC_VICTIM, 6'd0);
    write_reg(REG_FRAMES, 32'd1);
    send_item(FUNC_VICTIM, 6'd5);
    write_reg(REG_POLICY, {31'd0, MODE_CLOCK});
  endtask

  // Frame counts of zero and above the maximum, a hand past a lowered count,
  // and a reference to a frame that is not yet in use.
  task automatic test_count_edges();
    write_reg(REG_FRAMES, 32'd0);
    send_item(FUNC_VICTIM, 6'd9);
    write_reg(REG_FRAMES, 32'd127);
    send_item(FUNC_VICTIM, 6'd0);
    send_item(FUNC_VICTIM, 6'd0);
    send_item(FUNC_VICTIM, 6'd0);
    write_reg(REG_FRAMES, 32'd2);
    send_item(FUNC_REF, 6'd5);
    send_item(FUNC_VICTIM, 6'd0);
    write_reg(REG_FRAMES, 32'd8);
    repeat (5) send_item(FUNC_VICTIM, 6'd0);
  endtask

  task automatic send_random(input int count, input int victim_pct);
    logic fn;
    logic [INDEX_W-1:0] idx;
    for (int i = 0; i < count; i++) begin
      fn = ($urandom_range(99) < victim_pct) ? FUNC_VICTIM : FUNC_REF;
      if ($urandom_range(99) < 75) idx = INDEX_W'($urandom_range(frames_used() - 1));
      else idx = INDEX_W'($urandom_range(FRAMES_MAX - 1));
      send_item(fn, idx);
    end
  endtask

  task automatic test_random_phases();
    int send_pcts[4] = '{0, 57, 0, 13};
    int recv_pcts[4] = '{0, 0, 57, 13};
    int counts[8] = '{64, 1, 2, 127, 0, 64, 16, 33};
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        write_reg(REG_POLICY, (s == 0) ? {31'd0, MODE_CLOCK} : $urandom_range(1));
        write_reg(REG_FRAMES, (p == 3 && s == 1) ? $urandom_range(3, 63) : counts[2*p+s]);
        send_idle_pct = send_pcts[p];
        recv_stall_pct = recv_pcts[p];
        send_random(70, $urandom_range(25, 60));
      end
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_POLICY, {31'd0, MODE_CLOCK});
    write_reg(REG_FRAMES, 32'd64);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    hold_seq++;
    send_random(40, 50);
    settle();
    send_random(10, 50);
  endtask

  initial begin
    policy_shadow = POLICY_RESET;
    frames_shadow = FRAMES_RESET;
    hand_shadow = 0;
    ref_bits_shadow = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_clock_basics();
    test_full_sweep();
    test_fifo_rotation();
    test_count_edges();
    test_random_phases();
    test_backpressure();
    settle();
    if (pending_victims.size() != 0) begin
      errors += pending_victims.size();
      $display("tb: %0d victims never arrived", pending_victims.size());
    end
    $display("tb: %0d references and %0d victim requests sent, %0d victims checked",
             refs_sent, victims_sent, victims_checked);
    $display("tb: %0d register writes over FIFO and clock modes, frame counts 0 to 127",
             settings_written);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
